@@ sv/ptte_pkg.sv @@
// Package for the postfix truth-table evaluator.
// Holds token codes, error codes, the stack status struct and column helper functions.
// No dependencies.
package ptte_pkg;

	localparam int COL_W = 64;

	// Token codes.
	localparam logic [2:0] OP_VAR   = 3'd0;
	localparam logic [2:0] OP_AND   = 3'd1;
	localparam logic [2:0] OP_OR    = 3'd2;
	localparam logic [2:0] OP_NOT   = 3'd3;
	localparam logic [2:0] OP_IMPLY = 3'd4;
	localparam logic [2:0] OP_XNOR  = 3'd5;
	localparam logic [2:0] OP_XOR   = 3'd6;

	// Error codes; within one token the priority is VARS, then OVER, then UNDER.
	localparam logic [1:0] ERR_OK    = 2'd0;
	localparam logic [1:0] ERR_UNDER = 2'd1;
	localparam logic [1:0] ERR_OVER  = 2'd2;
	localparam logic [1:0] ERR_VARS  = 2'd3;

	typedef logic [COL_W-1:0] column_t;

	// Status of one token's effect on the column stack.
	typedef struct packed {
		logic under;
		logic over;
		logic full;
		logic empty;
	} stack_stat_t;

	// Column of a variable whose row bit sits at position sh of the row number.
	function automatic column_t var_pattern(input logic [2:0] sh);
		column_t c;
		unique case (sh)
			3'd0:    c = 64'hAAAA_AAAA_AAAA_AAAA;
			3'd1:    c = 64'hCCCC_CCCC_CCCC_CCCC;
			3'd2:    c = 64'hF0F0_F0F0_F0F0_F0F0;
			3'd3:    c = 64'hFF00_FF00_FF00_FF00;
			3'd4:    c = 64'hFFFF_0000_FFFF_0000;
			3'd5:    c = 64'hFFFF_FFFF_0000_0000;
			default: c = '0;
		endcase
		return c;
	endfunction

	// Rows at and above 2^vars are not part of the table.
	function automatic column_t row_mask(input logic [2:0] vars);
		column_t m;
		unique case (vars)
			3'd0:    m = 64'h0000_0000_0000_0001;
			3'd1:    m = 64'h0000_0000_0000_0003;
			3'd2:    m = 64'h0000_0000_0000_000F;
			3'd3:    m = 64'h0000_0000_0000_00FF;
			3'd4:    m = 64'h0000_0000_0000_FFFF;
			3'd5:    m = 64'h0000_0000_FFFF_FFFF;
			default: m = '1;
		endcase
		return m;
	endfunction

endpackage

@@ sv/ptte_letter_map.sv @@
// Letter table of the postfix truth-table evaluator: maps variable letters to columns.
// Depends on ptte_pkg.
module ptte_letter_map #(
	parameter int MAX_VARS = 6
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   fire,
	input  logic                   is_var,
	input  logic                   last,
	input  logic [7:0]             symbol,
	input  logic [2:0]             vars,
	input  ptte_pkg::column_t      mask,
	output logic                   vars_err,
	output ptte_pkg::column_t      column
);

	localparam int CW = $clog2(MAX_VARS + 1);
	localparam int KW = (MAX_VARS > 1) ? $clog2(MAX_VARS) : 1;

	logic [7:0]    letter_q [MAX_VARS];
	logic [CW-1:0] seen_q;

	logic          hit;
	logic [KW-1:0] hit_k;
	logic          full;
	logic [2:0]    k_sel;
	logic [2:0]    sh;
	logic          add_new;

	// Lowest matching entry wins, as entries are unique anyway.
	always_comb begin
		hit   = 1'b0;
		hit_k = '0;
		for (int k = MAX_VARS - 1; k >= 0; k--) begin
			if ((CW'(k) < seen_q) && (letter_q[k] == symbol)) begin
				hit   = 1'b1;
				hit_k = KW'(k);
			end
		end
	end

	assign full    = (3'(seen_q) >= vars);
	assign add_new = fire && is_var && !hit && !full;
	assign k_sel   = hit ? 3'(hit_k) : 3'(seen_q);
	assign sh      = vars - 3'd1 - k_sel;

	always_comb begin
		if ((!hit && full) || (k_sel >= vars)) begin
			column = '0;
		end else begin
			column = ptte_pkg::var_pattern(sh) & mask;
		end
	end

	assign vars_err = is_var && !hit && full;

	always_ff @(posedge clk) begin
		if (add_new) begin
			letter_q[seen_q[KW-1:0]] <= symbol;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seen_q <= '0;
		end else if (fire && last) begin
			seen_q <= '0;
		end else if (add_new) begin
			seen_q <= seen_q + CW'(1);
		end
	end

endmodule

@@ sv/ptte_col_stack.sv @@
// Column stack of the postfix truth-table evaluator, built as a shifting register stack.
// Depends on ptte_pkg.
module ptte_col_stack #(
	parameter int STACK_DEPTH = 16
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  fire,
	input  logic [2:0]            opcode,
	input  logic                  last,
	input  ptte_pkg::column_t     push_col,
	input  ptte_pkg::column_t     mask,
	output ptte_pkg::column_t     top_after,
	output ptte_pkg::stack_stat_t stat
);

	localparam int LW = $clog2(STACK_DEPTH + 1);

	ptte_pkg::column_t ent_q [STACK_DEPTH];
	logic [LW-1:0]     level_q;
	logic [LW-1:0]     level_after;

	logic              is_push;
	logic              is_not;
	logic              is_bin;
	logic              full;
	logic              do_push;
	logic              do_not;
	logic              do_bin;
	ptte_pkg::column_t bin_res;

	always_comb begin
		is_push = 1'b0;
		is_not  = 1'b0;
		is_bin  = 1'b0;
		case (opcode) inside
			ptte_pkg::OP_VAR: is_push = 1'b1;
			ptte_pkg::OP_NOT: is_not  = 1'b1;
			ptte_pkg::OP_AND, ptte_pkg::OP_OR, ptte_pkg::OP_IMPLY,
			ptte_pkg::OP_XNOR, ptte_pkg::OP_XOR: is_bin = 1'b1;
			default: ;
		endcase
	end

	// The deeper column is the left operand.
	always_comb begin
		case (opcode)
			ptte_pkg::OP_AND:   bin_res = ent_q[1] & ent_q[0];
			ptte_pkg::OP_OR:    bin_res = ent_q[1] | ent_q[0];
			ptte_pkg::OP_IMPLY: bin_res = ~ent_q[1] | ent_q[0];
			ptte_pkg::OP_XNOR:  bin_res = ~(ent_q[1] ^ ent_q[0]);
			default:            bin_res = ent_q[1] ^ ent_q[0];
		endcase
	end

	assign full    = (level_q == LW'(STACK_DEPTH));
	assign do_push = fire && is_push && !full;
	assign do_not  = fire && is_not && (level_q >= LW'(1));
	assign do_bin  = fire && is_bin && (level_q >= LW'(2));

	always_comb begin
		top_after   = ent_q[0];
		level_after = level_q;
		if (do_push) begin
			top_after   = push_col;
			level_after = level_q + LW'(1);
		end else if (do_not) begin
			top_after = ~ent_q[0] & mask;
		end else if (do_bin) begin
			top_after   = bin_res & mask;
			level_after = level_q - LW'(1);
		end
	end

	assign stat.under = (is_not && (level_q < LW'(1))) || (is_bin && (level_q < LW'(2)));
	assign stat.over  = is_push && full;
	assign stat.full  = full;
	assign stat.empty = (level_after == '0);

	always_ff @(posedge clk) begin
		if (do_push) begin
			ent_q[0] <= push_col;
			for (int i = 1; i < STACK_DEPTH; i++) begin
				ent_q[i] <= ent_q[i-1];
			end
		end else if (do_not || do_bin) begin
			ent_q[0] <= top_after;
			if (do_bin) begin
				for (int i = 1; i < STACK_DEPTH - 1; i++) begin
					ent_q[i] <= ent_q[i+1];
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			level_q <= '0;
		end else if (fire && last) begin
			level_q <= '0;
		end else if (fire) begin
			level_q <= level_after;
		end
	end

endmodule

@@ sv/postfix_truth_table_evaluator.sv @@
// Postfix truth-table evaluator. Tokens of a propositional formula arrive in postfix order,
// one beat per token: a beat is captured in an input register, then applied to the column
// stack and letter table, and a token marked last loads the result register, so a new
// token is accepted every cycle unless a last token is held behind a stalled result. The
// single path that sets this rate is the letter compare plus one 64-bit bitwise stack
// operation. While a result waits on a stalled output, tokens that are not last keep
// flowing. The num_vars register must be written only while no token is held in the input
// register and no result is outstanding.

module postfix_truth_table_evaluator #(
	parameter int MAX_VARS    = 6,
	parameter int STACK_DEPTH = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	// Configuration: number of variables, rows = 2^num_vars.
	input  logic        cfg_wr_en,
	input  logic [2:0]  cfg_wr_data,
	// Token channel.
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [2:0]  opcode,
	input  logic [7:0]  symbol,
	input  logic        last,
	// Result channel.
	output logic        out_valid,
	input  logic        out_stall,
	output logic [63:0] truth_column,
	output logic [1:0]  error_code
);

	// Configuration register.
	logic [2:0] num_vars_q;
	logic [2:0] used_vars;
	ptte_pkg::column_t mask;

	// Input stage.
	logic       valid_s1;
	logic [2:0] opcode_s1;
	logic [7:0] symbol_s1;
	logic       last_s1;
	logic       in_fire;
	logic       adv_s1;
	logic       fire_s1;

	// Per-formula error that sticks until the last token.
	logic [1:0] err_q;
	logic [1:0] tok_err;
	logic [1:0] err_mid;
	logic [1:0] err_final;

	// Datapath between the units.
	logic                  vars_err;
	ptte_pkg::column_t     var_col;
	ptte_pkg::column_t     top_after;
	ptte_pkg::stack_stat_t stat;

	// Output register.
	logic              out_valid_q;
	ptte_pkg::column_t truth_column_q;
	logic [1:0]        error_code_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			num_vars_q <= 3'd1;
		end else if (cfg_wr_en) begin
			num_vars_q <= cfg_wr_data;
		end
	end

	// A zero count acts as one variable, and the count is capped at the table size.
	always_comb begin
		if (num_vars_q == 3'd0) begin
			used_vars = 3'd1;
		end else if (num_vars_q > 3'(MAX_VARS)) begin
			used_vars = 3'(MAX_VARS);
		end else begin
			used_vars = num_vars_q;
		end
	end

	assign mask = ptte_pkg::row_mask(used_vars);

	// The held token moves on unless it is last and the result register cannot take it.
	assign adv_s1   = !last_s1 || !out_valid_q || !out_stall;
	assign fire_s1  = valid_s1 && adv_s1;
	assign in_stall = valid_s1 && !adv_s1;
	assign in_fire  = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_fire) begin
			valid_s1 <= 1'b1;
		end else if (fire_s1) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			opcode_s1 <= opcode;
			symbol_s1 <= symbol;
			last_s1   <= last;
		end
	end

	ptte_letter_map #(
		.MAX_VARS (MAX_VARS)
	) u_letters (
		.clk      (clk),
		.arst_n   (arst_n),
		.fire     (fire_s1),
		.is_var   (opcode_s1 == ptte_pkg::OP_VAR),
		.last     (last_s1),
		.symbol   (symbol_s1),
		.vars     (used_vars),
		.mask     (mask),
		.vars_err (vars_err),
		.column   (var_col)
	);

	ptte_col_stack #(
		.STACK_DEPTH (STACK_DEPTH)
	) u_stack (
		.clk       (clk),
		.arst_n    (arst_n),
		.fire      (fire_s1),
		.opcode    (opcode_s1),
		.last      (last_s1),
		.push_col  (var_col),
		.mask      (mask),
		.top_after (top_after),
		.stat      (stat)
	);

	// Within one token a variable overflow is seen before a stack overflow on its push.
	always_comb begin
		if (vars_err) begin
			tok_err = ptte_pkg::ERR_VARS;
		end else if (stat.over) begin
			tok_err = ptte_pkg::ERR_OVER;
		end else if (stat.under) begin
			tok_err = ptte_pkg::ERR_UNDER;
		end else begin
			tok_err = ptte_pkg::ERR_OK;
		end
	end

	// Only the first error of a formula is kept.
	assign err_mid = (err_q == ptte_pkg::ERR_OK) ? tok_err : err_q;

	// An empty stack at the end of a formula counts as an underflow.
	assign err_final = ((err_mid == ptte_pkg::ERR_OK) && stat.empty) ?
		ptte_pkg::ERR_UNDER : err_mid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			err_q <= ptte_pkg::ERR_OK;
		end else if (fire_s1) begin
			err_q <= last_s1 ? ptte_pkg::ERR_OK : err_mid;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (fire_s1 && last_s1) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fire_s1 && last_s1) begin
			truth_column_q <= stat.empty ? '0 : (top_after & mask);
			error_code_q   <= err_final;
		end
	end

	assign out_valid    = out_valid_q;
	assign truth_column = truth_column_q;
	assign error_code   = error_code_q;

	// The input side stalls only while a token is held in the input register.
	assert property (@(posedge clk) disable iff (!arst_n) in_stall |-> valid_s1)
		else $error("input stalled with no token held");

	// The error state starts clean after every formula.
	assert property (@(posedge clk) disable iff (!arst_n)
		(fire_s1 && last_s1) |=> (err_q == ptte_pkg::ERR_OK))
		else $error("pending error not cleared at end of formula");

	// A result taken from an empty stack always carries an error.
	assert property (@(posedge clk) disable iff (!arst_n)
		(fire_s1 && last_s1 && stat.empty) |=>
		(out_valid && (error_code != ptte_pkg::ERR_OK) && (truth_column == '0)))
		else $error("empty stack result without error");

	// An overflow is only flagged against a full stack.
	assert property (@(posedge clk) disable iff (!arst_n) stat.over |-> stat.full)
		else $error("overflow flagged on a stack that is not full");

endmodule

@@ verif/ptte_check_pkg.sv @@
// Result checker for the postfix truth-table evaluator testbench.
// Holds the token record, a column-stack predictor and the store of awaited result beats.
// Depends on ptte_pkg for the column type, token codes and error codes.
package ptte_check_pkg;

	import ptte_pkg::*;

	localparam int STACK_SLOTS  = 16;
	localparam int LETTER_SLOTS = 6;

	// The one opcode value with no operation behind it.
	localparam logic [2:0] OP_SPARE = 3'd7;

	typedef struct packed {
		logic [2:0] op;
		logic [7:0] sym;
		logic       lst;
	} token_t;

	typedef struct packed {
		column_t    col;
		logic [1:0] code;
	} table_result_t;

	class formula_checker;
		column_t       col_stack[STACK_SLOTS];
		int unsigned   depth;
		logic [7:0]    letters[LETTER_SLOTS];
		int unsigned   n_letters;
		logic [1:0]    held_err;
		logic [2:0]    vars_reg;
		table_result_t awaited_tables[$];
		int unsigned   mismatches;
		int unsigned   tables_seen;
		int unsigned   tokens_seen;

		function new();
			depth       = 0;
			n_letters   = 0;
			held_err    = ERR_OK;
			vars_reg    = 3'd1;
			mismatches  = 0;
			tables_seen = 0;
			tokens_seen = 0;
		endfunction

		function void set_vars(logic [2:0] v);
			vars_reg = v;
		endfunction

		function int unsigned pending();
			return awaited_tables.size();
		endfunction

		// Zero selects one variable and anything past six selects six.
		function int unsigned used_vars();
			if (vars_reg == 3'd0)
				return 1;
			if (vars_reg > 3'd6)
				return 6;
			return vars_reg;
		endfunction

		function column_t live_rows(int unsigned v);
			if (v >= 6)
				return '1;
			return (column_t'(1) << (1 << v)) - column_t'(1);
		endfunction

		// Variable k toggles with row bit (v-1-k), so the first letter is the slowest one.
		function column_t letter_column(int unsigned k, int unsigned v);
			column_t c;
			int      sh;
			c  = '0;
			sh = int'(v) - 1 - int'(k);
			for (int r = 0; r < COL_W; r++) begin
				if (((r >> sh) & 1) == 1)
					c[r] = 1'b1;
			end
			return c & live_rows(v);
		endfunction

		// Only the first error of a formula survives.
		function void note_error(logic [1:0] code);
			if (held_err == ERR_OK)
				held_err = code;
		endfunction

		function void push_column(column_t c);
			if (depth >= STACK_SLOTS) begin
				note_error(ERR_OVER);
				return;
			end
			col_stack[depth] = c;
			depth++;
		endfunction

		function void take_token(logic [2:0] op, logic [7:0] sym, logic lst);
			int unsigned   v;
			column_t       m;
			column_t       a;
			column_t       b;
			column_t       r;
			bit            found;
			table_result_t res;
			v     = used_vars();
			m     = live_rows(v);
			found = 1'b0;
			tokens_seen++;
			case (op)
				OP_VAR: begin
					for (int k = 0; k < n_letters; k++) begin
						if (!found && letters[k] == sym) begin
							found = 1'b1;
							push_column(letter_column(k, v));
						end
					end
					if (!found) begin
						if (n_letters >= v) begin
							// A letter beyond the table gets an all-zero column.
							note_error(ERR_VARS);
							push_column('0);
						end else begin
							letters[n_letters] = sym;
							n_letters++;
							push_column(letter_column(n_letters - 1, v));
						end
					end
				end
				OP_NOT: begin
					if (depth < 1)
						note_error(ERR_UNDER);
					else
						col_stack[depth-1] = ~col_stack[depth-1] & m;
				end
				OP_AND, OP_OR, OP_IMPLY, OP_XNOR, OP_XOR: begin
					if (depth < 2) begin
						note_error(ERR_UNDER);
					end else begin
						b = col_stack[depth-1];
						a = col_stack[depth-2];
						case (op)
							OP_AND:   r = a & b;
							OP_OR:    r = a | b;
							OP_IMPLY: r = ~a | b;
							OP_XNOR:  r = ~(a ^ b);
							default:  r = a ^ b;
						endcase
						depth--;
						col_stack[depth-1] = r & m;
					end
				end
				default: ;
			endcase
			if (!lst)
				return;
			res.col = '0;
			if (depth == 0)
				note_error(ERR_UNDER);
			else
				res.col = col_stack[depth-1] & m;
			res.code = held_err;
			awaited_tables.push_back(res);
			depth     = 0;
			n_letters = 0;
			held_err  = ERR_OK;
		endfunction

		function void check_table(column_t col, logic [1:0] code);
			table_result_t exp;
			tables_seen++;
			if (awaited_tables.size() == 0) begin
				$error("result beat with no formula waiting: truth_column %h error_code %0d",
					col, code);
				mismatches++;
				return;
			end
			exp = awaited_tables.pop_front();
			if (col !== exp.col) begin
				$error("truth_column: expected %h, actual %h", exp.col, col);
				mismatches++;
			end
			if (code !== exp.code) begin
				$error("error_code: expected %0d, actual %0d", exp.code, code);
				mismatches++;
			end
		endfunction
	endclass

endpackage

@@ verif/tb_top.sv @@
// Top-level testbench for the postfix truth-table evaluator.
// Drives token beats, backpressures result beats and checks each one against formula_checker.
// Depends on ptte_pkg and ptte_check_pkg.
module tb_top;

	timeunit 1ns;
	timeprecision 1ps;

	import ptte_pkg::*;
	import ptte_check_pkg::*;

	localparam logic [2:0] BIN_OPS [5] = '{OP_AND, OP_OR, OP_IMPLY, OP_XNOR, OP_XOR};
	localparam logic [7:0] LTR_A = 8'h61;
	localparam logic [7:0] LTR_B = 8'h62;
	localparam logic [7:0] LTR_C = 8'h63;

	logic        clk         = 1'b0;
	logic        arst_n      = 1'b0;
	logic        cfg_wr_en   = 1'b0;
	logic [2:0]  cfg_wr_data = 3'd0;
	logic        in_valid    = 1'b0;
	logic        in_stall;
	logic [2:0]  opcode      = OP_VAR;
	logic [7:0]  symbol      = 8'd0;
	logic        last        = 1'b0;
	logic        out_valid;
	logic        out_stall   = 1'b0;
	logic [63:0] truth_column;
	logic [1:0]  error_code;

	// Both sides stop idling while this is set.
	logic        quiet       = 1'b0;
	// Asks the result side for one long hold-off; it never goes low again.
	logic        hold_req    = 1'b0;

	// Result-side bookkeeping, touched only by the receiver process.
	int          rx_stall_left = 0;
	int          rx_hold_left  = 0;
	bit          rx_hold_done  = 1'b0;

	int unsigned settings_run = 0;

	formula_checker tables = new();
	token_t         formula_q[$];

	postfix_truth_table_evaluator uut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_wr_en    (cfg_wr_en),
		.cfg_wr_data  (cfg_wr_data),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.opcode       (opcode),
		.symbol       (symbol),
		.last         (last),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.truth_column (truth_column),
		.error_code   (error_code)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// Result side. Values are read right after the edge, before any nonblocking update,
	// so a beat counts when out_valid was high and our stall was low going into the edge.
	// The stall for the next cycle comes from three sources in order of priority: the one
	// long hold-off that lets tokens pile up until the block stalls its input, the quiet
	// stretches with no backpressure at all, and random bursts of stall.
	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid && !out_stall)
				tables.check_table(truth_column, error_code);
			if (hold_req && !rx_hold_done) begin
				rx_hold_done = 1'b1;
				rx_hold_left = 300;
			end
			if (rx_hold_left > 0) begin
				rx_hold_left--;
				out_stall <= 1'b1;
			end else if (quiet) begin
				rx_stall_left = 0;
				out_stall <= 1'b0;
			end else if (rx_stall_left > 0) begin
				rx_stall_left--;
				out_stall <= 1'b1;
			end else if ($urandom_range(0, 9) == 0) begin
				rx_stall_left = $urandom_range(1, 19) - 1;
				out_stall <= 1'b1;
			end else begin
				out_stall <= 1'b0;
			end
		end
	end

	function automatic void add_token(logic [2:0] op, logic [7:0] sym, logic lst);
		token_t t;
		t.op  = op;
		t.sym = sym;
		t.lst = lst;
		formula_q.push_back(t);
	endfunction

	// Marks the newest token of the queue as the end of its formula.
	function automatic void close_formula();
		formula_q[formula_q.size()-1].lst = 1'b1;
	endfunction

	function automatic int unsigned clamp_vars(logic [2:0] v);
		if (v == 3'd0)
			return 1;
		if (v > 3'd6)
			return 6;
		return v;
	endfunction

	// Distinct letter codes: an odd stride never repeats within 256 steps.
	function automatic logic [7:0] pick_letter(logic [7:0] base, logic [7:0] stride, int pool);
		return base + stride * 8'($urandom_range(0, pool - 1));
	endfunction

	// Well-formed postfix: leaves are pushed while fewer than two columns are waiting, or
	// at random otherwise; binary operators fold the stack and NOT is sprinkled in, so the
	// formula ends with exactly one column. The depth never passes the leaf count.
	function automatic void build_clean(int leaves, int pool);
		logic [7:0] base;
		logic [7:0] stride;
		int         d;
		int         left;
		base   = 8'($urandom_range(0, 255));
		stride = 8'($urandom_range(0, 127) * 2 + 1);
		d      = 0;
		left   = leaves;
		while (left > 0 || d > 1) begin
			if (left > 0 && (d < 2 || $urandom_range(0, 2) != 0)) begin
				add_token(OP_VAR, pick_letter(base, stride, pool), 1'b0);
				d++;
				left--;
			end else begin
				add_token(BIN_OPS[$urandom_range(0, 4)], 8'($urandom_range(0, 255)), 1'b0);
				d--;
			end
			if ($urandom_range(0, 5) == 0)
				add_token(OP_NOT, 8'($urandom_range(0, 255)), 1'b0);
		end
		close_formula();
	endfunction

	// More pushes than the stack holds, then a few operators on the full stack.
	function automatic void build_overflow(int pool);
		logic [7:0] base;
		logic [7:0] stride;
		base   = 8'($urandom_range(0, 255));
		stride = 8'($urandom_range(0, 127) * 2 + 1);
		repeat (STACK_SLOTS + $urandom_range(1, 3))
			add_token(OP_VAR, pick_letter(base, stride, pool), 1'b0);
		repeat ($urandom_range(0, 3))
			add_token(BIN_OPS[$urandom_range(0, 4)], 8'($urandom_range(0, 255)), 1'b0);
		close_formula();
	endfunction

	// Any opcode, the spare one included, in any order: mostly underflow and odd endings.
	function automatic void build_noise(int pool);
		logic [7:0] base;
		logic [7:0] stride;
		logic [7:0] sym;
		base   = 8'($urandom_range(0, 255));
		stride = 8'($urandom_range(0, 127) * 2 + 1);
		repeat ($urandom_range(1, 8)) begin
			if ($urandom_range(0, 1) == 0)
				sym = pick_letter(base, stride, pool);
			else
				sym = 8'($urandom_range(0, 255));
			add_token(3'($urandom_range(0, 7)), sym, 1'b0);
		end
		close_formula();
	endfunction

	// One token beat. An optional idle burst comes first, so that valid is lowered and
	// raised again in different cycles. The payload then holds until the beat is taken.
	task automatic send_token(token_t t);
		if (!quiet && $urandom_range(0, 7) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 19)) @(posedge clk);
		end
		in_valid <= 1'b1;
		opcode   <= t.op;
		symbol   <= t.sym;
		last     <= t.lst;
		do
			@(posedge clk);
		while (in_stall);
		tables.take_token(t.op, t.sym, t.lst);
	endtask

	// Sends the queued tokens and returns how many of them do any work.
	task automatic send_formula(output int unsigned n_real);
		n_real = 0;
		foreach (formula_q[i]) begin
			send_token(formula_q[i]);
			if (formula_q[i].op != OP_SPARE)
				n_real++;
		end
		formula_q.delete();
	endtask

	// The register may only change while nothing is in flight. Every formula ends with a
	// last token, so no token is held once no result is awaited; the task then idles before
	// the write.
	task automatic write_vars(logic [2:0] v);
		in_valid <= 1'b0;
		while (tables.pending() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
		cfg_wr_en   <= 1'b1;
		cfg_wr_data <= v;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		tables.set_vars(v);
		settings_run++;
	endtask

	task automatic run_setting(logic [2:0] v, int unsigned budget);
		int unsigned sent;
		int unsigned n;
		int unsigned eff;
		int unsigned pick;
		write_vars(v);
		eff  = clamp_vars(v);
		sent = 0;
		while (sent < budget) begin
			pick = $urandom_range(0, 99);
			if (pick < 72)
				build_clean(($urandom_range(0, 9) == 0) ? $urandom_range(9, 12)
					: $urandom_range(1, 8), eff);
			else if (pick < 82)
				build_clean($urandom_range(eff + 1, eff + 4), eff + 1);
			else if (pick < 87)
				build_overflow(eff);
			else
				build_noise(eff + 1);
			send_formula(n);
			sent += n;
		end
	endtask

	initial begin
		int unsigned n;
		logic [2:0]  plan [9];

		plan = '{3'd1, 3'd6, 3'd0, 3'd3, 3'd7, 3'd4, 3'd5, 3'd2, 3'd6};

		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part, two variables. Letter codes at both extremes, every operator,
		// underflow on an empty stack, an empty stack at the last token, a third letter
		// beyond the table, and the spare opcode both alone and after a push.
		write_vars(3'd2);
		add_token(OP_VAR,   8'h00, 1'b0);
		add_token(OP_VAR,   8'hFF, 1'b0);
		add_token(OP_AND,   8'h00, 1'b1);
		add_token(OP_VAR,   LTR_A, 1'b0);
		add_token(OP_VAR,   LTR_B, 1'b0);
		add_token(OP_OR,    8'hFF, 1'b0);
		add_token(OP_VAR,   LTR_A, 1'b0);
		add_token(OP_VAR,   LTR_B, 1'b0);
		add_token(OP_IMPLY, 8'h00, 1'b0);
		add_token(OP_XNOR,  8'h00, 1'b1);
		add_token(OP_VAR,   LTR_B, 1'b0);
		add_token(OP_VAR,   LTR_A, 1'b0);
		add_token(OP_XOR,   8'h00, 1'b0);
		add_token(OP_NOT,   8'h00, 1'b1);
		add_token(OP_AND,   8'h00, 1'b1);
		add_token(OP_VAR,   LTR_A, 1'b0);
		add_token(OP_VAR,   LTR_B, 1'b0);
		add_token(OP_VAR,   LTR_C, 1'b0);
		add_token(OP_AND,   8'h00, 1'b0);
		add_token(OP_AND,   8'h00, 1'b1);
		add_token(OP_SPARE, 8'h00, 1'b1);
		add_token(OP_VAR,   LTR_A, 1'b0);
		add_token(OP_SPARE, 8'hFF, 1'b1);
		send_formula(n);

		// Random part over several settings, out-of-range values included. The third
		// setting holds the result side off for a long stretch, one setting in the
		// middle and the closing one run without any idling.
		foreach (plan[i]) begin
			quiet <= (i == 5 || i == 8);
			if (i == 2)
				hold_req <= 1'b1;
			run_setting(plan[i], 142);
		end

		in_valid <= 1'b0;
		while (tables.pending() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);

		$display("Run covered %0d token beats and %0d result beats over %0d num_vars settings,",
			tables.tokens_seen, tables.tables_seen, settings_run);
		$display("including overflow, underflow, letter-table exhaustion and a long output hold.");
		if (tables.mismatches == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

	// Hard stop far beyond the slowest correct run.
	initial begin
		#2_000_000;
		$display("end of test: mismatches");
		$finish;
	end

endmodule
